// ===== design/tcis_pkg.sv =====
package tcis_pkg;

  localparam int MEM_DEPTH = 256;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int NUM_REGS  = 16;
  localparam int RF_AW     = $clog2(NUM_REGS);
  localparam int PC_W      = 9;

  localparam logic [1:0] REQ_WRITE_MEM = 2'd0;
  localparam logic [1:0] REQ_READ_MEM  = 2'd1;
  localparam logic [1:0] REQ_EXEC      = 2'd2;
  localparam logic [1:0] REQ_READ_REG  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_HALTED = 2'd1;
  localparam logic [1:0] ST_BAD_OP = 2'd2;
  localparam logic [1:0] ST_AT_END = 2'd3;

  localparam logic [3:0] OP_LOAD  = 4'h1;
  localparam logic [3:0] OP_LDI   = 4'h2;
  localparam logic [3:0] OP_STORE = 4'h3;
  localparam logic [3:0] OP_MOVE  = 4'h4;
  localparam logic [3:0] OP_ADD   = 4'h5;
  localparam logic [3:0] OP_JEQ   = 4'hB;
  localparam logic [3:0] OP_HALT  = 4'hC;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] address;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [PC_W-1:0] program_counter;
    logic [15:0]     instruction;
    logic [7:0]      read_data;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRITE,
    S_MRD,
    S_RRD,
    S_FHI,
    S_FLO,
    S_DEC,
    S_OPA,
    S_OPB,
    S_WB,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    ASEL_REQ,
    ASEL_PC,
    ASEL_PC1,
    ASEL_XY
  } asel_t;

  typedef enum logic [2:0] {
    RSEL_REQ,
    RSEL_R,
    RSEL_X,
    RSEL_Y,
    RSEL_ZERO
  } rsel_t;

  typedef enum logic [1:0] {
    WB_LOAD,
    WB_IMM,
    WB_MOVE,
    WB_ADD
  } wb_t;

  typedef enum logic [1:0] {
    PC_HOLD,
    PC_INC,
    PC_BRANCH
  } pcop_t;

  typedef struct packed {
    logic  cap_req;
    logic  mem_we;
    logic  mem_re;
    asel_t mem_asel;
    logic  rf_re;
    rsel_t rf_rsel;
    logic  rf_we;
    wb_t   rf_wsel;
    logic  lat_hi;
    logic  lat_lo;
    logic  lat_opa;
    pcop_t pc_op;
    logic  out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic       at_end;
    logic [3:0] op;
  } dp_stat_t;

endpackage

// ===== design/teaching_cpu_instruction_step.sv =====
// channel   | ports                              | payload
// ----------+------------------------------------+---------------------
// input     | in_valid, in_ready, in_data        | tcis_pkg::in_item_t
// result    | out_valid, out_ready, out_data     | tcis_pkg::out_item_t
// config    | cfg_valid, cfg_ready, cfg_data     | program_end, 9 bits
//
// one item at a time: a memory write or a memory or register read does its access
// and then loads the result, a step at program end goes straight to the result,
// and an executed step makes two fetch reads and at most one operand access
// on the single-port memory and up to two register file reads, per the controller.
// reset is synchronous; memory and registers read as zero until written.
// a stalled result holds in the output register; the next item can be taken
// in the cycle after that result is loaded, and cfg_ready is always high.
module teaching_cpu_instruction_step (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tcis_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tcis_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tcis_pkg::PC_W-1:0]       cfg_data
);

  tcis_pkg::dp_cmd_t  cmd;
  tcis_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  tcis_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_data.req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  tcis_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_valid),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// ===== design/tcis_ctrl.sv =====
module tcis_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  output logic               out_valid,
  input  logic               out_ready,
  input  tcis_pkg::dp_stat_t stat,
  output tcis_pkg::dp_cmd_t  cmd
);

  tcis_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == tcis_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcis_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcis_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_req_type)
            tcis_pkg::REQ_WRITE_MEM: state_nxt = tcis_pkg::S_WRITE;
            tcis_pkg::REQ_READ_MEM:  state_nxt = tcis_pkg::S_MRD;
            tcis_pkg::REQ_READ_REG:  state_nxt = tcis_pkg::S_RRD;
            default: begin
              state_nxt = stat.at_end ? tcis_pkg::S_DONE : tcis_pkg::S_FHI;
            end
          endcase
        end
      end
      tcis_pkg::S_WRITE: state_nxt = tcis_pkg::S_DONE;
      tcis_pkg::S_MRD:   state_nxt = tcis_pkg::S_DONE;
      tcis_pkg::S_RRD:   state_nxt = tcis_pkg::S_DONE;
      tcis_pkg::S_FHI:   state_nxt = tcis_pkg::S_FLO;
      tcis_pkg::S_FLO:   state_nxt = tcis_pkg::S_DEC;
      tcis_pkg::S_DEC:   state_nxt = tcis_pkg::S_OPA;
      tcis_pkg::S_OPA: begin
        case (stat.op)
          tcis_pkg::OP_LOAD,
          tcis_pkg::OP_STORE,
          tcis_pkg::OP_MOVE: state_nxt = tcis_pkg::S_WB;
          tcis_pkg::OP_ADD,
          tcis_pkg::OP_JEQ:  state_nxt = tcis_pkg::S_OPB;
          default:           state_nxt = tcis_pkg::S_DONE;
        endcase
      end
      tcis_pkg::S_OPB:   state_nxt = tcis_pkg::S_WB;
      tcis_pkg::S_WB:    state_nxt = tcis_pkg::S_DONE;
      tcis_pkg::S_DONE: begin
        if (slot_free) begin
          state_nxt = tcis_pkg::S_IDLE;
        end
      end
      default: state_nxt = tcis_pkg::S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.cap_req   = 1'b0;
    cmd.mem_we    = 1'b0;
    cmd.mem_re    = 1'b0;
    cmd.mem_asel  = tcis_pkg::ASEL_REQ;
    cmd.rf_re     = 1'b0;
    cmd.rf_rsel   = tcis_pkg::RSEL_REQ;
    cmd.rf_we     = 1'b0;
    cmd.rf_wsel   = tcis_pkg::WB_LOAD;
    cmd.lat_hi    = 1'b0;
    cmd.lat_lo    = 1'b0;
    cmd.lat_opa   = 1'b0;
    cmd.pc_op     = tcis_pkg::PC_HOLD;
    cmd.out_load  = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      tcis_pkg::S_IDLE: begin
        cmd.cap_req = in_valid;
      end
      tcis_pkg::S_WRITE: begin
        cmd.mem_we = 1'b1;
      end
      tcis_pkg::S_MRD: begin
        cmd.mem_re = 1'b1;
      end
      tcis_pkg::S_RRD: begin
        cmd.rf_re = 1'b1;
      end
      tcis_pkg::S_FHI: begin
        cmd.mem_re   = 1'b1;
        cmd.mem_asel = tcis_pkg::ASEL_PC;
      end
      tcis_pkg::S_FLO: begin
        cmd.mem_re   = 1'b1;
        cmd.mem_asel = tcis_pkg::ASEL_PC1;
        cmd.lat_hi   = 1'b1;
      end
      tcis_pkg::S_DEC: begin
        cmd.lat_lo = 1'b1;
      end
      tcis_pkg::S_OPA: begin
        case (stat.op)
          tcis_pkg::OP_LOAD: begin
            cmd.mem_re   = 1'b1;
            cmd.mem_asel = tcis_pkg::ASEL_XY;
          end
          tcis_pkg::OP_LDI: begin
            cmd.rf_we   = 1'b1;
            cmd.rf_wsel = tcis_pkg::WB_IMM;
            cmd.pc_op   = tcis_pkg::PC_INC;
          end
          tcis_pkg::OP_STORE,
          tcis_pkg::OP_JEQ: begin
            cmd.rf_re   = 1'b1;
            cmd.rf_rsel = tcis_pkg::RSEL_R;
          end
          tcis_pkg::OP_MOVE,
          tcis_pkg::OP_ADD: begin
            cmd.rf_re   = 1'b1;
            cmd.rf_rsel = tcis_pkg::RSEL_X;
          end
          default: begin
            cmd.pc_op = tcis_pkg::PC_INC;
          end
        endcase
      end
      tcis_pkg::S_OPB: begin
        cmd.lat_opa = 1'b1;
        cmd.rf_re   = 1'b1;
        cmd.rf_rsel = (stat.op == tcis_pkg::OP_ADD) ? tcis_pkg::RSEL_Y : tcis_pkg::RSEL_ZERO;
      end
      tcis_pkg::S_WB: begin
        case (stat.op)
          tcis_pkg::OP_LOAD: begin
            cmd.rf_we   = 1'b1;
            cmd.rf_wsel = tcis_pkg::WB_LOAD;
            cmd.pc_op   = tcis_pkg::PC_INC;
          end
          tcis_pkg::OP_STORE: begin
            cmd.mem_we   = 1'b1;
            cmd.mem_asel = tcis_pkg::ASEL_XY;
            cmd.pc_op    = tcis_pkg::PC_INC;
          end
          tcis_pkg::OP_MOVE: begin
            cmd.rf_we   = 1'b1;
            cmd.rf_wsel = tcis_pkg::WB_MOVE;
            cmd.pc_op   = tcis_pkg::PC_INC;
          end
          tcis_pkg::OP_ADD: begin
            cmd.rf_we   = 1'b1;
            cmd.rf_wsel = tcis_pkg::WB_ADD;
            cmd.pc_op   = tcis_pkg::PC_INC;
          end
          default: begin
            cmd.pc_op = tcis_pkg::PC_BRANCH;
          end
        endcase
      end
      tcis_pkg::S_DONE: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/tcis_dpath.sv =====
module tcis_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tcis_pkg::in_item_t           in_data,
  input  logic                         cfg_we,
  input  logic [tcis_pkg::PC_W-1:0]    cfg_data,
  input  tcis_pkg::dp_cmd_t            cmd,
  output tcis_pkg::dp_stat_t           stat,
  output tcis_pkg::out_item_t          out_data
);

  localparam int PW = tcis_pkg::PC_W;

  logic [7:0]    mem [tcis_pkg::MEM_DEPTH];
  logic [tcis_pkg::MEM_DEPTH-1:0] mem_vld_r;
  logic [7:0]    mem_q_r;
  logic          mem_qv_r;
  logic [7:0]    rf [tcis_pkg::NUM_REGS];
  logic [tcis_pkg::NUM_REGS-1:0] rf_vld_r;
  logic [7:0]    rf_q_r;
  logic          rf_qv_r;

  logic [PW-1:0] pc_r, pe_r;
  logic [1:0]    req_r;
  logic [7:0]    addr_r, wdata_r;
  logic          end_r;
  logic [7:0]    ir_hi_r, ir_lo_r, opa_r;
  tcis_pkg::out_item_t out_r;

  logic [15:0]   ir;
  logic [PW-1:0] mem_addr, pc_inc;
  logic          mem_in_range;
  logic [tcis_pkg::MEM_AW-1:0] mem_idx;
  logic [7:0]    mem_wdata, mem_rdata, rf_rdata;
  logic [tcis_pkg::RF_AW-1:0] rf_raddr, rf_waddr;
  logic [7:0]    rf_wdata;
  logic [1:0]    status;

  assign ir        = {ir_hi_r, ir_lo_r};
  assign pc_inc    = pc_r + PW'(2);
  assign mem_rdata = mem_qv_r ? mem_q_r : 8'd0;
  assign rf_rdata  = rf_qv_r ? rf_q_r : 8'd0;

  assign stat.at_end = (pc_r >= pe_r);
  assign stat.op     = ir[15:12];
  assign out_data    = out_r;

  always_comb begin
    case (cmd.mem_asel)
      tcis_pkg::ASEL_REQ:  mem_addr = {1'b0, addr_r};
      tcis_pkg::ASEL_PC:   mem_addr = pc_r;
      tcis_pkg::ASEL_PC1:  mem_addr = pc_r + PW'(1);
      tcis_pkg::ASEL_XY:   mem_addr = {1'b0, ir[7:0]};
      default:             mem_addr = pc_r;
    endcase
  end

  assign mem_in_range = (mem_addr < PW'(tcis_pkg::MEM_DEPTH));
  assign mem_idx      = mem_addr[tcis_pkg::MEM_AW-1:0];
  assign mem_wdata    = (cmd.mem_asel == tcis_pkg::ASEL_XY) ? rf_rdata : wdata_r;

  always_comb begin
    case (cmd.rf_rsel)
      tcis_pkg::RSEL_REQ:  rf_raddr = addr_r[tcis_pkg::RF_AW-1:0];
      tcis_pkg::RSEL_R:    rf_raddr = ir[11:8];
      tcis_pkg::RSEL_X:    rf_raddr = ir[7:4];
      tcis_pkg::RSEL_Y:    rf_raddr = ir[3:0];
      default:             rf_raddr = '0;
    endcase
  end

  always_comb begin
    case (cmd.rf_wsel)
      tcis_pkg::WB_LOAD: begin
        rf_waddr = ir[11:8];
        rf_wdata = mem_rdata;
      end
      tcis_pkg::WB_IMM: begin
        rf_waddr = ir[11:8];
        rf_wdata = ir[7:0];
      end
      tcis_pkg::WB_MOVE: begin
        rf_waddr = ir[3:0];
        rf_wdata = rf_rdata;
      end
      default: begin
        rf_waddr = ir[11:8];
        rf_wdata = opa_r + rf_rdata;
      end
    endcase
  end

  always_comb begin
    if (req_r != tcis_pkg::REQ_EXEC) begin
      status = tcis_pkg::ST_OK;
    end else if (end_r) begin
      status = tcis_pkg::ST_AT_END;
    end else begin
      case (ir[15:12])
        tcis_pkg::OP_HALT: status = tcis_pkg::ST_HALTED;
        tcis_pkg::OP_LOAD,
        tcis_pkg::OP_LDI,
        tcis_pkg::OP_STORE,
        tcis_pkg::OP_MOVE,
        tcis_pkg::OP_ADD,
        tcis_pkg::OP_JEQ:  status = tcis_pkg::ST_OK;
        default:           status = tcis_pkg::ST_BAD_OP;
      endcase
    end
  end

  // main memory, single port
  always_ff @(posedge clk) begin
    if (cmd.mem_we && mem_in_range) begin
      mem[mem_idx] <= mem_wdata;
    end
    if (cmd.mem_re) begin
      mem_q_r <= mem[mem_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_vld_r <= '0;
      mem_qv_r  <= 1'b0;
    end else begin
      if (cmd.mem_we && mem_in_range) begin
        mem_vld_r[mem_idx] <= 1'b1;
      end
      if (cmd.mem_re) begin
        mem_qv_r <= mem_in_range && mem_vld_r[mem_idx];
      end
    end
  end

  // register file
  always_ff @(posedge clk) begin
    if (cmd.rf_we) begin
      rf[rf_waddr] <= rf_wdata;
    end
    if (cmd.rf_re) begin
      rf_q_r <= rf[rf_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
      rf_qv_r  <= 1'b0;
    end else begin
      if (cmd.rf_we) begin
        rf_vld_r[rf_waddr] <= 1'b1;
      end
      if (cmd.rf_re) begin
        rf_qv_r <= rf_vld_r[rf_raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
      pe_r <= '0;
    end else begin
      if (cfg_we) begin
        pe_r <= cfg_data;
      end
      case (cmd.pc_op)
        tcis_pkg::PC_INC:    pc_r <= pc_inc;
        tcis_pkg::PC_BRANCH: pc_r <= (opa_r == rf_rdata) ? {1'b0, ir[7:0]} : pc_inc;
        default:             pc_r <= pc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_req) begin
      req_r   <= in_data.req_type;
      addr_r  <= in_data.address;
      wdata_r <= in_data.write_data;
      end_r   <= stat.at_end;
      ir_hi_r <= 8'd0;
      ir_lo_r <= 8'd0;
    end else begin
      if (cmd.lat_hi) begin
        ir_hi_r <= mem_rdata;
      end
      if (cmd.lat_lo) begin
        ir_lo_r <= mem_rdata;
      end
    end
    if (cmd.lat_opa) begin
      opa_r <= rf_rdata;
    end
    if (cmd.out_load) begin
      out_r.status          <= status;
      out_r.program_counter <= pc_r;
      out_r.instruction     <= (req_r == tcis_pkg::REQ_EXEC) ? ir : 16'd0;
      case (req_r)
        tcis_pkg::REQ_READ_MEM: out_r.read_data <= mem_rdata;
        tcis_pkg::REQ_READ_REG: out_r.read_data <= rf_rdata;
        default:                out_r.read_data <= 8'd0;
      endcase
    end
  end

endmodule

// ===== design/tcis_chk.sv =====
module tcis_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input tcis_pkg::out_item_t       out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  a_end_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == tcis_pkg::ST_AT_END |->
      out_data.instruction == 16'd0 && out_data.read_data == 8'd0)
    else $error("program end result carries data");

  a_err_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != tcis_pkg::ST_OK |-> out_data.read_data == 8'd0)
    else $error("step result carries read data");

endmodule

bind teaching_cpu_instruction_step tcis_chk u_chk (.*);
